/* rtl/zfd_pkg.sv */
// zfd_pkg: types, constants and small lookup functions for the zstd frame delimiter
// no dependencies; imported by every module under rtl/
package zfd_pkg;

    localparam int MAX_BLOCK_BYTES = 131072;
    localparam int SEG_W           = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int BSIZE_W         = 21;
    localparam int CFG_W           = 32;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONTENT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COMPRESSED = 1'b1;

    localparam logic [CFG_W-1:0] MAX_CONTENT_RST    = 32'd16777216;
    localparam logic [CFG_W-1:0] MAX_COMPRESSED_RST = 32'd16908288;

    localparam int PREFIX_BYTES   = 5;
    localparam int BLKHDR_BYTES   = 3;
    localparam int CHECKSUM_BYTES = 4;

    // result status codes; the error codes double as the sticky error value
    localparam logic [1:0] ST_IN_FRAME = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_PROTO    = 2'd2;
    localparam logic [1:0] ST_LIMIT    = 2'd3;
    localparam logic [1:0] ERR_NONE    = 2'd0;

    localparam logic [1:0] BT_RLE      = 2'd1;
    localparam logic [1:0] BT_RESERVED = 2'd3;

    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_HEADER = 3'd1,
        PH_BLKHDR = 3'd2,
        PH_BODY   = 3'd3,
        PH_CHECK  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] max_content;
        logic [CFG_W-1:0] max_compressed;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  byte_part;
        logic        frame_end;
        logic [1:0]  status;
        logic [31:0] content_size;
        logic        size_known;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  err;
        logic [31:0] frame_len;
    } t_parse_mon;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] m;
        unique case (pos)
            2'd0: m = 8'h28;
            2'd1: m = 8'hb5;
            2'd2: m = 8'h2f;
            default: m = 8'hfd;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] dict_len(input logic [1:0] code);
        logic [2:0] n;
        unique case (code)
            2'd0: n = 3'd0;
            2'd1: n = 3'd1;
            2'd2: n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    // a single-segment frame with no size code still carries a one-byte size
    function automatic logic [3:0] fcs_len(input logic [1:0] code, input logic single);
        logic [3:0] n;
        unique case (code)
            2'd0: n = {3'd0, single};
            2'd1: n = 4'd2;
            2'd2: n = 4'd4;
            default: n = 4'd8;
        endcase
        return n;
    endfunction

endpackage

/* rtl/zfd_cfg.sv */
// zfd_cfg: limit registers written through the plain configuration write port
// depends on zfd_pkg
module zfd_cfg import zfd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [CFG_W-1:0]     i_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_content    <= MAX_CONTENT_RST;
            r_cfg.max_compressed <= MAX_COMPRESSED_RST;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_MAX_CONTENT:    r_cfg.max_content    <= i_wdata;
                CFG_MAX_COMPRESSED: r_cfg.max_compressed <= i_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/zfd_parser.sv */
// zfd_parser: frame parse state and the per-byte decision logic
// depends on zfd_pkg; advanced one byte per i_step by the top level
module zfd_parser import zfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result,
    output t_parse_mon o_mon
);

    t_phase            r_phase, n_phase;
    logic [SEG_W-1:0]  r_seg, n_seg;
    logic [7:0]        r_desc, n_desc;
    logic [23:0]       r_bh, n_bh;
    logic [31:0]       r_cs, n_cs;
    logic              r_cs_hi, n_cs_hi;
    logic              r_dict_nz, n_dict_nz;
    logic [31:0]       r_fl, n_fl;
    logic [1:0]        r_err, n_err;

    logic [7:0]        desc_sel;
    logic              win;
    logic [2:0]        dlen;
    logic [3:0]        flen;
    logic [3:0]        hdr_len;
    logic [3:0]        hpos;
    logic [3:0]        cs_start;
    logic [2:0]        cs_k;
    logic              is_dict_byte;
    logic              is_cs_byte;
    logic [31:0]       cs_new;
    logic              cs_hi_new;
    logic [31:0]       cs_fin;
    logic              cs_over;
    logic [1:0]        bh_idx;
    logic [23:0]       bh_new;
    logic [1:0]        btype;
    logic [BSIZE_W-1:0] bsize;
    logic              oversize;
    logic [SEG_W-1:0]  body_len;
    logic [SEG_W-1:0]  seg_dec;
    logic [31:0]       fl_inc;
    logic [SEG_W-1:0]  need;
    logic [32:0]       room_sum;
    logic              room_ok;
    logic [1:0]        step_err;
    logic              step_end;
    logic              show_size;

    // header layout comes from the incoming byte while it is the descriptor
    assign desc_sel = (r_phase == PH_MAGIC) ? i_byte : r_desc;
    assign win      = ~desc_sel[5];
    assign dlen     = dict_len(desc_sel[1:0]);
    assign flen     = fcs_len(desc_sel[7:6], desc_sel[5]);
    assign hdr_len  = 4'(win) + 4'(dlen) + flen;

    assign hpos         = hdr_len - r_seg[3:0];
    assign cs_start     = 4'(win) + 4'(dlen);
    assign cs_k         = 3'(hpos - cs_start);
    assign is_dict_byte = (hpos >= 4'(win)) && (hpos < cs_start);
    assign is_cs_byte   = (hpos >= cs_start);

    // only the low 32 bits of the size are kept; upper bytes just flag nonzero
    assign cs_new    = (is_cs_byte && !cs_k[2])
                     ? (r_cs | (32'(i_byte) << {cs_k[1:0], 3'b000})) : r_cs;
    assign cs_hi_new = r_cs_hi | (is_cs_byte && cs_k[2] && (i_byte != 8'd0));
    assign cs_fin    = cs_new + ((flen == 4'd2) ? 32'd256 : 32'd0);
    assign cs_over   = (flen != 4'd0) && (cs_hi_new || (cs_fin > i_cfg.max_content));

    assign bh_idx   = 2'd3 - r_seg[1:0];
    assign bh_new   = r_bh | (24'(i_byte) << {bh_idx, 3'b000});
    assign btype    = bh_new[2:1];
    assign bsize    = bh_new[23:3];
    assign oversize = bsize > BSIZE_W'(MAX_BLOCK_BYTES);
    assign body_len = (btype == BT_RLE) ? SEG_W'(1) : bsize[SEG_W-1:0];

    assign seg_dec = r_seg - SEG_W'(1);
    assign fl_inc  = r_fl + 32'd1;

    // bytes the next segment needs, after the byte now arriving
    always_comb begin : seg_need
        unique case (r_phase)
            PH_MAGIC:  need = (r_fl == 32'd0) ? SEG_W'(PREFIX_BYTES - 1) : SEG_W'(hdr_len);
            PH_HEADER: need = SEG_W'(BLKHDR_BYTES);
            PH_BLKHDR: begin
                if (body_len != '0) begin
                    need = body_len;
                end else if (!bh_new[0]) begin
                    need = SEG_W'(BLKHDR_BYTES);
                end else begin
                    need = r_desc[2] ? SEG_W'(CHECKSUM_BYTES) : '0;
                end
            end
            PH_BODY: begin
                if (!r_bh[0]) begin
                    need = SEG_W'(BLKHDR_BYTES);
                end else begin
                    need = r_desc[2] ? SEG_W'(CHECKSUM_BYTES) : '0;
                end
            end
            default: need = '0;
        endcase
    end

    // frame length after this byte plus the next segment must stay within the limit
    assign room_sum = {1'b0, r_fl} + 33'(need) + 33'd1;
    assign room_ok  = room_sum <= {1'b0, i_cfg.max_compressed};

    always_comb begin : next_state
        n_phase   = r_phase;
        n_seg     = r_seg;
        n_desc    = r_desc;
        n_bh      = r_bh;
        n_cs      = r_cs;
        n_cs_hi   = r_cs_hi;
        n_dict_nz = r_dict_nz;
        n_fl      = r_fl;
        n_err     = r_err;
        step_err  = ERR_NONE;
        step_end  = 1'b0;
        if (r_err == ERR_NONE) begin
            unique case (r_phase)
                PH_MAGIC: begin
                    if (r_fl == 32'd0) begin
                        n_cs      = '0;
                        n_cs_hi   = 1'b0;
                        n_dict_nz = 1'b0;
                    end
                    if (r_fl == 32'd0 && !room_ok) begin
                        step_err = ST_LIMIT;
                    end else begin
                        n_fl = fl_inc;
                        if (r_fl < 32'd4) begin
                            if (i_byte != magic_byte(r_fl[1:0])) step_err = ST_PROTO;
                        end else begin
                            n_desc = i_byte;
                            if (i_byte[3]) begin
                                step_err = ST_PROTO;
                            end else if (!room_ok) begin
                                step_err = ST_LIMIT;
                            end else begin
                                n_phase = PH_HEADER;
                                n_seg   = SEG_W'(hdr_len);
                            end
                        end
                    end
                end
                PH_HEADER: begin
                    n_fl    = fl_inc;
                    n_seg   = seg_dec;
                    n_cs    = cs_new;
                    n_cs_hi = cs_hi_new;
                    if (is_dict_byte && i_byte != 8'd0) n_dict_nz = 1'b1;
                    if (r_seg == SEG_W'(1)) begin
                        n_cs = cs_fin;
                        if (cs_over) begin
                            step_err = ST_LIMIT;
                        end else if (n_dict_nz) begin
                            step_err = ST_PROTO;
                        end else if (!room_ok) begin
                            step_err = ST_LIMIT;
                        end else begin
                            n_bh    = '0;
                            n_phase = PH_BLKHDR;
                            n_seg   = SEG_W'(BLKHDR_BYTES);
                        end
                    end
                end
                PH_BLKHDR: begin
                    n_fl  = fl_inc;
                    n_bh  = bh_new;
                    n_seg = seg_dec;
                    if (r_seg == SEG_W'(1)) begin
                        if (btype == BT_RESERVED || oversize) begin
                            step_err = ST_PROTO;
                        end else if (!room_ok) begin
                            step_err = ST_LIMIT;
                        end else if (body_len != '0) begin
                            n_phase = PH_BODY;
                            n_seg   = body_len;
                        end else if (!bh_new[0]) begin
                            n_bh    = '0;
                            n_phase = PH_BLKHDR;
                            n_seg   = SEG_W'(BLKHDR_BYTES);
                        end else if (r_desc[2]) begin
                            n_phase = PH_CHECK;
                            n_seg   = SEG_W'(CHECKSUM_BYTES);
                        end else begin
                            step_end = 1'b1;
                        end
                    end
                end
                PH_BODY: begin
                    n_fl  = fl_inc;
                    n_seg = seg_dec;
                    if (r_seg == SEG_W'(1)) begin
                        // last block without checksum ends the frame with no room check
                        if (r_bh[0] && !r_desc[2]) begin
                            step_end = 1'b1;
                        end else if (!room_ok) begin
                            step_err = ST_LIMIT;
                        end else if (!r_bh[0]) begin
                            n_bh    = '0;
                            n_phase = PH_BLKHDR;
                            n_seg   = SEG_W'(BLKHDR_BYTES);
                        end else begin
                            n_phase = PH_CHECK;
                            n_seg   = SEG_W'(CHECKSUM_BYTES);
                        end
                    end
                end
                default: begin
                    // checksum bytes
                    n_fl = fl_inc;
                    if (r_seg != '0) n_seg = seg_dec;
                    if (r_seg <= SEG_W'(1)) step_end = 1'b1;
                end
            endcase
            if (step_err != ERR_NONE) n_err = step_err;
            if (step_end) begin
                n_phase = PH_MAGIC;
                n_fl    = '0;
                n_seg   = '0;
                n_bh    = '0;
            end
        end
    end

    assign show_size = step_end || (n_phase >= PH_BLKHDR);

    always_comb begin : outputs
        o_result.byte_out     = i_byte;
        o_result.byte_part    = r_phase;
        o_result.frame_end    = 1'b0;
        o_result.status       = ST_IN_FRAME;
        o_result.content_size = '0;
        o_result.size_known   = 1'b0;
        if (r_err != ERR_NONE) begin
            o_result.byte_part = 3'd0;
            o_result.status    = r_err;
        end else if (step_err != ERR_NONE) begin
            o_result.status = step_err;
        end else begin
            o_result.frame_end = step_end;
            o_result.status    = step_end ? ST_DONE : ST_IN_FRAME;
            if (show_size && flen != 4'd0) begin
                o_result.size_known   = 1'b1;
                o_result.content_size = n_cs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAGIC;
            r_seg     <= '0;
            r_desc    <= '0;
            r_bh      <= '0;
            r_cs      <= '0;
            r_cs_hi   <= 1'b0;
            r_dict_nz <= 1'b0;
            r_fl      <= '0;
            r_err     <= ERR_NONE;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_seg     <= n_seg;
            r_desc    <= n_desc;
            r_bh      <= n_bh;
            r_cs      <= n_cs;
            r_cs_hi   <= n_cs_hi;
            r_dict_nz <= n_dict_nz;
            r_fl      <= n_fl;
            r_err     <= n_err;
        end
    end

    assign o_mon.phase     = r_phase;
    assign o_mon.err       = r_err;
    assign o_mon.frame_len = r_fl;

endmodule

/* rtl/zstd_frame_delimiter.sv */
// zstd_frame_delimiter: top level, input beat register, parser, result register
// depends on zfd_pkg, zfd_cfg, zfd_parser
//
// Usage:
//   s_axis carries the compressed stream, one byte per beat in tdata[7:0].
//   m_axis returns one beat per input byte: the byte, its status and the
//   declared content size in tdata, the frame part code in tuser, and tlast
//   on the last byte of each frame.
//   The limit registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_wdata while no bytes are in flight.
// Timing:
//   an accepted byte waits in the input register and is parsed into the
//   result register once that register is empty or its beat is taken.
//   One byte per cycle is sustained while m_axis_tready stays high; the per-byte
//   decision is a single pass through the parser logic, the longest path being
//   the frame-room add and compare against the compressed size limit.
// Reset: synchronous, active low; both channels go empty, parse state returns
//   to expecting a frame magic and the limits return to their defaults.
// Stall: when m_axis_tready is low the result register holds, the input
//   register takes one more byte, and then s_axis_tready drops.
// Errors stick until reset; later bytes still pass through with the error.
module zstd_frame_delimiter import zfd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] stream_byte
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // [7:0] byte_out, [9:8] status,
                                                 // [41:10] content_size, [42] size_known
    output logic [2:0]           m_axis_tuser,   // [2:0] byte_part
    output logic                 m_axis_tlast    // frame_end
);

    t_cfg       cfg;
    t_result    result;
    t_parse_mon mon;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       adv;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    zfd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    zfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_result (result),
        .o_mon    (mon)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.size_known, r_out.content_size,
                            r_out.status, r_out.byte_out};
    assign m_axis_tuser  = r_out.byte_part;
    assign m_axis_tlast  = r_out.frame_end;

`ifndef ASSERT_OFF
    // once raised, the error code never changes until reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mon.err != ERR_NONE) |=> (mon.err == $past(mon.err)))
        else $error("sticky error changed");

    // past the magic phase the whole five-byte prefix has been counted
    a_prefix_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mon.err == ERR_NONE && mon.phase != PH_MAGIC) |-> (mon.frame_len >= 32'd5))
        else $error("frame length short of prefix in later phase");

    // a frame end beat always reports a completed frame
    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_end) |-> (r_out.status == ST_DONE))
        else $error("frame end without complete status");

    // a held input beat is not consumed or altered while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && r_in_byte == $past(r_in_byte)))
        else $error("pending input beat lost");
`endif

endmodule

/* tb/zstd_frame_delimiter_test.sv */
`timescale 1ns / 1ps
// zstd_frame_delimiter_test: self-checking bench for the zstd frame delimiter
// streams well-formed frames under several limit settings and one closing fault,
// predicts every result beat in a small tracker class; depends on zfd_pkg and the rtl
module zstd_frame_delimiter_test;
    import zfd_pkg::*;

    localparam logic [31:0] ZSTD_MAGIC    = 32'hfd2fb528;   // first stream byte lowest
    localparam logic [1:0]  BT_RAW        = 2'd0;
    localparam logic [1:0]  BT_COMPRESSED = 2'd2;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 8;

    typedef enum int {
        FAULT_MAGIC,
        FAULT_RESERVED_BIT,
        FAULT_BLOCK_TYPE,
        FAULT_OVERSIZE,
        FAULT_DICT_ID,
        FAULT_CONTENT_SIZE,
        FAULT_FRAME_LENGTH,
        FAULT_LIMIT_LOWERED
    } t_fault;

    // follows the parse of every accepted byte and holds the labelled bytes still owed
    class frame_tracker;
        logic [31:0] lim_content;
        logic [31:0] lim_frame;
        t_phase      phase;
        int unsigned seg_left;
        logic [7:0]  desc;
        logic [23:0] bhdr;
        logic [63:0] csize_acc;
        bit          dict_nz;
        logic [31:0] flen;
        logic [1:0]  sticky;
        t_result     labelled[$];
        int unsigned n_checked;
        int unsigned n_frames;
        int unsigned n_bad;
        logic [1:0]  last_status;

        function new();
            lim_content = MAX_CONTENT_RST;
            lim_frame   = MAX_COMPRESSED_RST;
            phase       = PH_MAGIC;
            seg_left    = 0;
            desc        = '0;
            bhdr        = '0;
            csize_acc   = '0;
            dict_nz     = 1'b0;
            flen        = '0;
            sticky      = ERR_NONE;
            n_checked   = 0;
            n_frames    = 0;
            n_bad       = 0;
            last_status = ST_IN_FRAME;
        endfunction

        static function void head_sizes(input logic [7:0] d, output int unsigned win,
                                        output int unsigned dct, output int unsigned fcs);
            win = d[5] ? 0 : 1;
            case (d[1:0])
                2'd0: dct = 0;
                2'd1: dct = 1;
                2'd2: dct = 2;
                default: dct = 4;
            endcase
            case (d[7:6])
                2'd0: fcs = d[5];
                2'd1: fcs = 2;
                2'd2: fcs = 4;
                default: fcs = 8;
            endcase
        endfunction

        function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            if (idx == CFG_MAX_CONTENT) begin
                lim_content = value;
            end else begin
                lim_frame = value;
            end
        endfunction

        // a frame already past a lowered limit has no room at all
        function bit fits(int unsigned need);
            if (flen > lim_frame) return 1'b0;
            return need <= lim_frame - flen;
        endfunction

        function logic [1:0] open_seg(t_phase nxt, int unsigned count);
            if (!fits(count)) return ST_LIMIT;
            phase    = nxt;
            seg_left = count;
            return ERR_NONE;
        endfunction

        function logic [1:0] block_done(inout bit fin);
            if (bhdr[0]) begin
                if (desc[2]) return open_seg(PH_CHECK, CHECKSUM_BYTES);
                fin = 1'b1;
                return ERR_NONE;
            end
            bhdr = '0;
            return open_seg(PH_BLKHDR, BLKHDR_BYTES);
        endfunction

        function void note_byte(logic [7:0] b);
            t_result     r;
            t_phase      part;
            logic [1:0]  err;
            logic [1:0]  btype;
            logic [31:0] pos;
            bit          fin;
            int unsigned win, dct, fcs, p, k, bsize;
            r          = '0;
            r.byte_out = b;
            if (sticky != ERR_NONE) begin
                r.status = sticky;
                labelled.push_back(r);
                return;
            end
            part = phase;
            err  = ERR_NONE;
            fin  = 1'b0;
            case (phase)
                PH_MAGIC: begin
                    pos = flen;
                    if (pos == 0) begin
                        csize_acc = '0;
                        dict_nz   = 1'b0;
                    end
                    if (pos == 0 && !fits(PREFIX_BYTES)) begin
                        err = ST_LIMIT;
                    end else begin
                        flen = pos + 1;
                        if (pos < 4) begin
                            if (b != ZSTD_MAGIC[8*pos[1:0] +: 8]) err = ST_PROTO;
                        end else begin
                            desc = b;
                            if (b[3]) begin
                                err = ST_PROTO;
                            end else begin
                                head_sizes(desc, win, dct, fcs);
                                err = open_seg(PH_HEADER, win + dct + fcs);
                            end
                        end
                    end
                end
                PH_HEADER: begin
                    head_sizes(desc, win, dct, fcs);
                    p = (win + dct + fcs - seg_left) & 15;
                    flen++;
                    if (p >= win && p < win + dct) begin
                        if (b != 0) dict_nz = 1'b1;
                    end else if (p >= win + dct) begin
                        k = (p - win - dct) & 7;
                        csize_acc = csize_acc | ({56'd0, b} << (8 * k));
                    end
                    seg_left--;
                    if (seg_left == 0) begin
                        // a two-byte size is stored minus 256
                        if (fcs == 2) csize_acc = csize_acc + 256;
                        if (fcs != 0 && csize_acc > {32'd0, lim_content}) begin
                            err = ST_LIMIT;
                        end else if (dict_nz) begin
                            err = ST_PROTO;
                        end else begin
                            bhdr = '0;
                            err  = open_seg(PH_BLKHDR, BLKHDR_BYTES);
                        end
                    end
                end
                PH_BLKHDR: begin
                    k = (3 - seg_left) & 3;
                    flen++;
                    bhdr = bhdr | ({16'd0, b} << (8 * k));
                    seg_left--;
                    if (seg_left == 0) begin
                        btype = bhdr[2:1];
                        bsize = bhdr[23:3];
                        if (btype == BT_RESERVED || bsize > MAX_BLOCK_BYTES) begin
                            err = ST_PROTO;
                        end else begin
                            if (btype == BT_RLE) bsize = 1;
                            if (bsize == 0) begin
                                err = fits(0) ? block_done(fin) : ST_LIMIT;
                            end else begin
                                err = open_seg(PH_BODY, bsize);
                            end
                        end
                    end
                end
                PH_BODY: begin
                    flen++;
                    seg_left--;
                    if (seg_left == 0) err = block_done(fin);
                end
                default: begin
                    flen++;
                    if (seg_left > 0) seg_left--;
                    if (seg_left == 0) fin = 1'b1;
                end
            endcase

            r.byte_part = part;
            if (err != ERR_NONE) begin
                sticky   = err;
                r.status = err;
                labelled.push_back(r);
                return;
            end
            r.frame_end = fin;
            r.status    = fin ? ST_DONE : ST_IN_FRAME;
            if (fin || phase >= PH_BLKHDR) begin
                head_sizes(desc, win, dct, fcs);
                r.size_known   = (fcs != 0);
                r.content_size = (fcs != 0) ? csize_acc[31:0] : 32'd0;
            end
            if (fin) begin
                phase    = PH_MAGIC;
                flen     = '0;
                seg_left = 0;
                bhdr     = '0;
                n_frames++;
            end
            labelled.push_back(r);
        endfunction

        function void check_beat(t_result got);
            t_result want;
            n_checked++;
            last_status = got.status;
            if (labelled.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("beat %0d arrived with nothing owed: byte %h part %0d status %0d",
                             n_checked, got.byte_out, got.byte_part, got.status);
                return;
            end
            want = labelled.pop_front();
            if (got.byte_out !== want.byte_out || got.byte_part !== want.byte_part ||
                got.frame_end !== want.frame_end || got.status !== want.status ||
                got.content_size !== want.content_size || got.size_known !== want.size_known)
            begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("mismatch at beat %0d: want byte %h part %0d last %0b status %0d",
                             n_checked, want.byte_out, want.byte_part, want.frame_end,
                             want.status, " size %0d known %0b",
                             want.content_size, want.size_known);
                    $display("                      got  byte %h part %0d last %0b status %0d",
                             got.byte_out, got.byte_part, got.frame_end, got.status,
                             " size %0d known %0b", got.content_size, got.size_known);
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_MAX_CONTENT;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;   // [7:0] byte_out, [9:8] status,
                                          // [41:10] content_size, [42] size_known
    logic [2:0]           m_axis_tuser;   // [2:0] byte_part
    logic                 m_axis_tlast;

    frame_tracker tracker = new();
    logic [7:0]   frame_buf[$];
    logic [7:0]   stim_q[$];
    int unsigned  src_gap = 0;
    int unsigned  snk_gap = 0;
    bit           src_idle = 1'b1;
    bit           snk_idle = 1'b1;
    int unsigned  cycle_count = 0;
    t_result      seen_beat;
    t_fault       closing_fault;

    zstd_frame_delimiter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // byte source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) tracker.note_byte(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    s_axis_tdata  <= stim_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    src_gap = src_idle ? pick_gap() : 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_beat.byte_out     = m_axis_tdata[7:0];
            seen_beat.status       = m_axis_tdata[9:8];
            seen_beat.content_size = m_axis_tdata[41:10];
            seen_beat.size_known   = m_axis_tdata[42];
            seen_beat.byte_part    = m_axis_tuser;
            seen_beat.frame_end    = m_axis_tlast;
            tracker.check_beat(seen_beat);
        end
        if (snk_gap > 0) begin
            snk_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            snk_gap = snk_idle ? pick_gap() : 0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d beats owed",
                     cycle_count, tracker.labelled.size());
            $display("FAIL zstd_frame_delimiter");
            $finish;
        end
    end

    function automatic void ship();
        foreach (frame_buf[i]) stim_q.push_back(frame_buf[i]);
    endfunction

    // magic, descriptor, window byte, dictionary id and content size
    function automatic void put_head(logic [7:0] d, logic [63:0] csize, bit dict_bad);
        int unsigned win, dct, fcs;
        int          bad_at;
        logic [63:0] stored;
        frame_tracker::head_sizes(d, win, dct, fcs);
        for (int i = 0; i < 4; i++) frame_buf.push_back(ZSTD_MAGIC[8*i +: 8]);
        frame_buf.push_back(d);
        if (win != 0) frame_buf.push_back(8'($urandom_range(0, 255)));
        bad_at = dict_bad ? $urandom_range(0, dct - 1) : -1;
        for (int i = 0; i < dct; i++)
            frame_buf.push_back((i == bad_at) ? 8'($urandom_range(1, 255)) : 8'h00);
        stored = (fcs == 2) ? csize - 64'd256 : csize;
        for (int i = 0; i < fcs; i++) frame_buf.push_back(stored[8*i +: 8]);
    endfunction

    function automatic void push_block(logic [1:0] btype, logic [20:0] bsize, bit last,
                                       bit with_body);
        logic [23:0] hdr;
        hdr = {bsize, btype, last};
        for (int i = 0; i < 3; i++) frame_buf.push_back(hdr[8*i +: 8]);
        if (with_body) begin
            if (btype == BT_RLE) begin
                frame_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                for (int i = 0; i < bsize; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // a valid frame that respects both current limits
    function automatic void random_frame(int unsigned body_max);
        logic [7:0]  d;
        logic [63:0] cs;
        logic [1:0]  bt;
        logic [20:0] bs;
        int unsigned win, dct, fcs, nblk, top;
        bit          done;
        done = 1'b0;
        for (int attempt = 0; attempt < 8 && !done; attempt++) begin
            frame_buf.delete();
            d    = 8'($urandom_range(0, 255));
            d[3] = 1'b0;
            frame_tracker::head_sizes(d, win, dct, fcs);
            case (fcs)
                1: cs = $urandom_range(0, 255);
                2: cs = 256 + $urandom_range(0, 65535);
                4: cs = ($urandom_range(0, 7) == 0) ? {32'd0, tracker.lim_content}
                                                    : {32'd0, $urandom()};
                8: cs = {32'd0, $urandom()};
                default: cs = '0;
            endcase
            if (fcs != 0 && cs > {32'd0, tracker.lim_content}) begin
                // fall back to a one-byte size that fits
                d[7:6] = 2'd0;
                d[5]   = 1'b1;
                top    = (tracker.lim_content < 255) ? tracker.lim_content : 255;
                cs     = $urandom_range(0, top);
            end
            put_head(d, cs, 1'b0);
            nblk = $urandom_range(1, 4);
            for (int i = 0; i < nblk; i++) begin
                bt = 2'($urandom_range(0, 2));
                if (bt == BT_RLE)
                    bs = ($urandom_range(0, 15) == 0) ? MAX_BLOCK_BYTES : $urandom_range(0, 300);
                else if ($urandom_range(0, 7) == 0)
                    bs = $urandom_range(0, body_max * 3);
                else
                    bs = $urandom_range(0, body_max);
                push_block(bt, bs, i == nblk - 1, 1'b1);
            end
            if (d[2]) for (int i = 0; i < 4; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
            done = (frame_buf.size() <= tracker.lim_frame);
        end
        if (!done) begin
            frame_buf.delete();
            put_head(8'h20, 64'd0, 1'b0);
            push_block(BT_RAW, 21'd0, 1'b1, 1'b1);
        end
    endfunction

    task automatic feed_random(int unsigned n_bytes, int unsigned body_max);
        int unsigned sent;
        sent = 0;
        @(negedge i_clk);
        while (sent < n_bytes) begin
            random_frame(body_max);
            sent += frame_buf.size();
            ship();
        end
    endtask

    task automatic feed_noise(int unsigned n_bytes);
        @(negedge i_clk);
        frame_buf.delete();
        repeat (n_bytes) frame_buf.push_back(8'($urandom_range(0, 255)));
        ship();
    endtask

    // wait until every byte is in and every beat is out
    task automatic settle();
        do @(negedge i_clk);
        while (stim_q.size() != 0 || s_axis_tvalid || tracker.labelled.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_limit(idx, value);
    endtask

    task automatic set_limits(logic [31:0] content_lim, logic [31:0] frame_lim);
        write_limit(CFG_MAX_CONTENT, content_lim);
        write_limit(CFG_MAX_COMPRESSED, frame_lim);
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
    endtask

    // errors stick until reset, so exactly one fault closes the run
    task automatic run_fault(t_fault kind);
        logic [7:0]  d;
        logic [31:0] lim;
        @(negedge i_clk);
        frame_buf.delete();
        case (kind)
            FAULT_MAGIC: begin
                random_frame(8);
                frame_buf[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            end
            FAULT_RESERVED_BIT: begin
                put_head(8'($urandom_range(0, 255)) | 8'h08, 64'd0, 1'b0);
            end
            FAULT_BLOCK_TYPE: begin
                put_head(8'h20, 64'($urandom_range(0, 255)), 1'b0);
                push_block(BT_RESERVED, 21'($urandom_range(0, 2097151)),
                           1'($urandom_range(0, 1)), 1'b0);
            end
            FAULT_OVERSIZE: begin
                put_head(8'h20, 64'($urandom_range(0, 255)), 1'b0);
                push_block(BT_COMPRESSED, 21'd4, 1'b0, 1'b1);
                push_block(2'($urandom_range(0, 2)),
                           21'($urandom_range(MAX_BLOCK_BYTES + 1, 2097151)), 1'b1, 1'b0);
            end
            FAULT_DICT_ID: begin
                d = 8'h20 | 8'($urandom_range(1, 3));
                put_head(d, 64'($urandom_range(0, 255)), 1'b1);
                push_block(BT_RAW, 21'd2, 1'b1, 1'b1);
            end
            FAULT_CONTENT_SIZE: begin
                lim = $urandom_range(1, 1000);
                write_limit(CFG_MAX_CONTENT, lim);
                @(negedge i_clk);
                if ($urandom_range(0, 1) == 0)
                    put_head(8'h80, {32'd0, lim + 1 + $urandom_range(0, 1000)}, 1'b0);
                else
                    put_head(8'he0, {32'($urandom_range(1, 255)), $urandom()}, 1'b0);
                push_block(BT_RAW, 21'd2, 1'b1, 1'b1);
            end
            FAULT_FRAME_LENGTH: begin
                write_limit(CFG_MAX_COMPRESSED, $urandom_range(1, 40));
                @(negedge i_clk);
                put_head(8'h20, 64'd7, 1'b0);
                push_block(BT_RAW, 21'd50, 1'b1, 1'b1);
            end
            default: begin
                // stop mid-frame, drop the limit below what has already passed
                put_head(8'h20, 64'($urandom_range(0, 255)), 1'b0);
                push_block(BT_RAW, 21'd5, 1'b0, 1'b1);
                ship();
                settle();
                write_limit(CFG_MAX_COMPRESSED, $urandom_range(1, frame_buf.size() - 1));
                @(negedge i_clk);
                frame_buf.delete();
                push_block(BT_RAW, 21'd3, 1'b1, 1'b1);
            end
        endcase
        ship();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one-byte size at its top, empty last block, then an rle block of
        // the largest size with checksum and no declared size
        @(negedge i_clk);
        frame_buf.delete();
        put_head(8'h20, 64'd255, 1'b0);
        push_block(BT_RAW, 21'd0, 1'b1, 1'b1);
        ship();
        frame_buf.delete();
        put_head(8'h04, 64'd0, 1'b0);
        push_block(BT_RLE, MAX_BLOCK_BYTES, 1'b1, 1'b1);
        for (int i = 0; i < 4; i++) frame_buf.push_back(8'hff);
        ship();
        settle();

        set_limits(32'hffff_ffff, 32'hffff_ffff);
        feed_random(200, 24);
        settle();
        set_limits(32'd1, $urandom_range(40, 90));
        feed_random(150, 12);
        settle();
        set_limits($urandom_range(256, 70000), $urandom_range(100, 3000));
        feed_random(220, 24);
        settle();
        set_limits(MAX_CONTENT_RST, MAX_COMPRESSED_RST);
        feed_random(220, 24);
        settle();

        closing_fault = t_fault'($urandom_range(0, 7));
        run_fault(closing_fault);
        feed_noise(40);
        settle();

        $display("checked %0d beats over %0d complete frames under five limit settings",
                 tracker.n_checked, tracker.n_frames);
        $display("closing fault %s left status %0d, %0d mismatches",
                 closing_fault.name(), tracker.last_status, tracker.n_bad);
        if (tracker.n_bad == 0 && tracker.labelled.size() == 0) begin
            $display("PASS zstd_frame_delimiter");
        end else begin
            $display("FAIL zstd_frame_delimiter");
        end
        $finish;
    end

endmodule
